/* sv/lrst_pkg.sv */
// Shared types and constants for the lazy range-add / range-sum tree unit.
package lrst_pkg;

  localparam int unsigned POSITIONS = 1024;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned DELTA_W   = 48;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned HALF_W    = 32;

  typedef struct packed {
    logic                      mode;
    logic [POS_W-1:0]          range_low;
    logic [POS_W-1:0]          range_high;
    logic signed [DELTA_W-1:0] delta;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] interval_sum;
    logic                    range_error;
  } out_item_t;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_VISIT,
    S_QACC,
    S_PDCHK,
    S_APRD,
    S_APM0,
    S_APM1,
    S_APWR,
    S_PDCLR,
    S_FIXL,
    S_FIXR,
    S_POP
  } state_e;

  typedef enum logic [1:0] {
    PH_ENTRY,
    PH_LEFT,
    PH_RIGHT,
    PH_FIX
  } phase_e;

  typedef enum logic [1:0] {
    RET_POP,
    RET_PD_RIGHT,
    RET_PD_CLEAR
  } ret_e;

  typedef struct packed {
    logic en;
    logic upper;
  } mac_ctl_t;

endpackage

/* sv/lrst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lrst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lrst_mac.sv */
// Shared multiplier: count times 64-bit addend, in two 32-bit halves.
module lrst_mac (
  input  logic                          clk_i,
  input  lrst_pkg::mac_ctl_t            ctl_i,
  input  logic [lrst_pkg::POS_W-1:0]    cnt_i,
  input  logic [lrst_pkg::SUM_W-1:0]    val_i,
  output logic [lrst_pkg::SUM_W-1:0]    prod_o
);

  localparam int unsigned PW = lrst_pkg::POS_W + lrst_pkg::HALF_W;

  logic [lrst_pkg::HALF_W-1:0] half;
  logic [PW-1:0]               part;
  logic [lrst_pkg::SUM_W-1:0]  acc_d, acc_q;

  always_comb begin
    half = ctl_i.upper ? val_i[lrst_pkg::SUM_W-1:lrst_pkg::HALF_W]
                       : val_i[lrst_pkg::HALF_W-1:0];
    part = PW'(cnt_i) * PW'(half);
    if (ctl_i.upper) begin
      acc_d = acc_q + {part[lrst_pkg::HALF_W-1:0], {lrst_pkg::HALF_W{1'b0}}};
    end else begin
      acc_d = lrst_pkg::SUM_W'(part);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = acc_q;

endmodule

/* sv/lazy_range_add_range_sum_tree_unit.sv */
// Top level: lazy segment tree sequencer with node stores and shared multiplier.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------------------
//  item in   | in        | start / busy               | in_item_i (lrst_pkg::in_item_t)
//  result    | out       | result_valid_o (strobe)    | result_o (lrst_pkg::out_item_t)
//  config    | in        | cfg_valid_i / cfg_ready_o  | cfg_data_i (size in use)
//
// After reset the node stores are swept to zero, one node a cycle, over all
// 4*POSITIONS nodes; busy is high meanwhile and config writes still land.
// Per visited node: a fully covered node is visited, read and popped for a query;
// an add visits, reads, makes two multiply passes, writes and pops. A partly
// covered node is checked for a pending addend and its children are visited; an
// add then reads both child sums back and writes their total. A pending addend is
// pushed to each child by a read, two multiply passes and a write, then cleared.
// Run time is set by the single node-store read port and the two-pass multiplier.
// Bad intervals finish at once: a query strobes its error result next cycle.
// Config is taken only while no item is in flight or being accepted.
// Results are strobed for one cycle; the receiver cannot stall.
module lazy_range_add_range_sum_tree_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lrst_pkg::in_item_t            in_item_i,
  output logic                          result_valid_o,
  output lrst_pkg::out_item_t           result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lrst_pkg::POS_W-1:0]    cfg_data_i
);

  localparam int unsigned POSITIONS = lrst_pkg::POSITIONS;
  localparam int unsigned NODES = 4 * POSITIONS;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned STK_D = $clog2(POSITIONS) + 2;
  localparam int unsigned SPW   = $clog2(STK_D);
  localparam int unsigned PW    = lrst_pkg::POS_W;
  localparam int unsigned SW    = lrst_pkg::SUM_W;

  lrst_pkg::state_e state_d, state_q;

  // recursion stack: one frame per tree level
  logic [NW-1:0]    stk_node_d [STK_D];
  logic [NW-1:0]    stk_node_q [STK_D];
  logic [PW-1:0]    stk_lo_d   [STK_D];
  logic [PW-1:0]    stk_lo_q   [STK_D];
  logic [PW-1:0]    stk_hi_d   [STK_D];
  logic [PW-1:0]    stk_hi_q   [STK_D];
  lrst_pkg::phase_e stk_ph_d   [STK_D];
  lrst_pkg::phase_e stk_ph_q   [STK_D];
  logic [SPW-1:0]   sp_d, sp_q;

  logic             mode_d, mode_q;
  logic [PW-1:0]    a_d, a_q, b_d, b_q, size_d, size_q;
  logic [SW-1:0]    v_d, v_q, acc_d, acc_q, left_d, left_q;
  logic [NW-1:0]    ap_node_d, ap_node_q, clr_d, clr_q;
  logic [PW-1:0]    ap_cnt_d, ap_cnt_q;
  logic [SW-1:0]    ap_val_d, ap_val_q;
  lrst_pkg::ret_e   ap_ret_d, ap_ret_q;
  logic             res_valid_d, res_valid_q;
  logic [SW-1:0]    res_sum_d, res_sum_q;
  logic             res_err_d, res_err_q;

  // node store ports
  logic             sum_we, pend_we, sum_re, pend_re;
  logic [NW-1:0]    waddr, raddr;
  logic [SW-1:0]    sum_wdata, pend_wdata, sum_rdata, pend_rdata;

  lrst_pkg::mac_ctl_t mac_ctl;
  logic [SW-1:0]      mac_prod;

  // top frame
  logic [NW-1:0]  t_node, t_left, t_right;
  logic [PW-1:0]  t_lo, t_hi, t_mid;
  logic [PW:0]    lohi;
  logic           covered, bad_in;
  logic [SPW-1:0] sp_up;

  assign t_node  = stk_node_q[sp_q];
  assign t_lo    = stk_lo_q[sp_q];
  assign t_hi    = stk_hi_q[sp_q];
  assign lohi    = {1'b0, t_lo} + {1'b0, t_hi};
  assign t_mid   = lohi[PW:1];
  assign t_left  = {t_node[NW-2:0], 1'b0};
  assign t_right = {t_node[NW-2:0], 1'b1};
  assign covered = (a_q <= t_lo) && (t_hi <= b_q);
  assign sp_up   = SPW'(sp_q + 1'b1);
  assign bad_in  = (in_item_i.range_low == '0)
                || (in_item_i.range_high < in_item_i.range_low)
                || (in_item_i.range_high > size_q);

  lrst_ram #(.WIDTH(SW), .DEPTH(NODES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (raddr),
    .rdata_o (sum_rdata)
  );

  lrst_ram #(.WIDTH(SW), .DEPTH(NODES)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (waddr),
    .wdata_i (pend_wdata),
    .re_i    (pend_re),
    .raddr_i (raddr),
    .rdata_o (pend_rdata)
  );

  lrst_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .cnt_i  (ap_cnt_q),
    .val_i  (ap_val_q),
    .prod_o (mac_prod)
  );

  // size register, clamped to 1..POSITIONS
  always_comb begin
    size_d = size_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i == '0) begin
        size_d = PW'(1);
      end else if (int'(cfg_data_i) > POSITIONS) begin
        size_d = PW'(POSITIONS);
      end else begin
        size_d = cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    stk_node_d  = stk_node_q;
    stk_lo_d    = stk_lo_q;
    stk_hi_d    = stk_hi_q;
    stk_ph_d    = stk_ph_q;
    sp_d        = sp_q;
    mode_d      = mode_q;
    a_d         = a_q;
    b_d         = b_q;
    v_d         = v_q;
    acc_d       = acc_q;
    left_d      = left_q;
    ap_node_d   = ap_node_q;
    ap_cnt_d    = ap_cnt_q;
    ap_val_d    = ap_val_q;
    ap_ret_d    = ap_ret_q;
    clr_d       = clr_q;
    res_valid_d = 1'b0;
    res_sum_d   = res_sum_q;
    res_err_d   = res_err_q;
    sum_we      = 1'b0;
    pend_we     = 1'b0;
    sum_re      = 1'b0;
    pend_re     = 1'b0;
    waddr       = t_node;
    raddr       = t_node;
    sum_wdata   = '0;
    pend_wdata  = '0;
    mac_ctl     = '0;

    unique case (state_q)
      lrst_pkg::S_CLEAR: begin
        sum_we  = 1'b1;
        pend_we = 1'b1;
        waddr   = clr_q;
        clr_d   = NW'(clr_q + 1'b1);
        if (clr_q == NW'(NODES - 1)) begin
          state_d = lrst_pkg::S_IDLE;
        end
      end

      lrst_pkg::S_IDLE: begin
        if (start) begin
          mode_d = in_item_i.mode;
          a_d    = in_item_i.range_low;
          b_d    = in_item_i.range_high;
          v_d    = SW'(in_item_i.delta);
          if (bad_in) begin
            if (in_item_i.mode == lrst_pkg::MODE_QUERY) begin
              res_valid_d = 1'b1;
              res_sum_d   = '0;
              res_err_d   = 1'b1;
            end
          end else begin
            sp_d          = '0;
            stk_node_d[0] = NW'(1);
            stk_lo_d[0]   = PW'(1);
            stk_hi_d[0]   = size_q;
            stk_ph_d[0]   = lrst_pkg::PH_ENTRY;
            acc_d         = '0;
            state_d       = lrst_pkg::S_VISIT;
          end
        end
      end

      lrst_pkg::S_VISIT: begin
        unique case (stk_ph_q[sp_q])
          lrst_pkg::PH_ENTRY: begin
            if (covered) begin
              if (mode_q == lrst_pkg::MODE_ADD) begin
                ap_node_d = t_node;
                ap_cnt_d  = PW'(t_hi - t_lo + 1'b1);
                ap_val_d  = v_q;
                ap_ret_d  = lrst_pkg::RET_POP;
                state_d   = lrst_pkg::S_APRD;
              end else begin
                sum_re  = 1'b1;
                state_d = lrst_pkg::S_QACC;
              end
            end else begin
              pend_re = 1'b1;
              state_d = lrst_pkg::S_PDCHK;
            end
          end
          lrst_pkg::PH_LEFT: begin
            stk_ph_d[sp_q] = lrst_pkg::PH_RIGHT;
            if (a_q <= t_mid) begin
              stk_node_d[sp_up] = t_left;
              stk_lo_d[sp_up]   = t_lo;
              stk_hi_d[sp_up]   = t_mid;
              stk_ph_d[sp_up]   = lrst_pkg::PH_ENTRY;
              sp_d              = sp_up;
            end
          end
          lrst_pkg::PH_RIGHT: begin
            stk_ph_d[sp_q] = lrst_pkg::PH_FIX;
            if (b_q > t_mid) begin
              stk_node_d[sp_up] = t_right;
              stk_lo_d[sp_up]   = PW'(t_mid + 1'b1);
              stk_hi_d[sp_up]   = t_hi;
              stk_ph_d[sp_up]   = lrst_pkg::PH_ENTRY;
              sp_d              = sp_up;
            end
          end
          lrst_pkg::PH_FIX: begin
            if (mode_q == lrst_pkg::MODE_ADD) begin
              sum_re  = 1'b1;
              raddr   = t_left;
              state_d = lrst_pkg::S_FIXL;
            end else begin
              state_d = lrst_pkg::S_POP;
            end
          end
          default: state_d = lrst_pkg::S_POP;
        endcase
      end

      lrst_pkg::S_QACC: begin
        acc_d   = acc_q + sum_rdata;
        state_d = lrst_pkg::S_POP;
      end

      // push-down: skip when nothing pending, else apply to both children
      lrst_pkg::S_PDCHK: begin
        if (pend_rdata == '0) begin
          stk_ph_d[sp_q] = lrst_pkg::PH_LEFT;
          state_d        = lrst_pkg::S_VISIT;
        end else begin
          ap_node_d = t_left;
          ap_cnt_d  = PW'(t_mid - t_lo + 1'b1);
          ap_val_d  = pend_rdata;
          ap_ret_d  = lrst_pkg::RET_PD_RIGHT;
          state_d   = lrst_pkg::S_APRD;
        end
      end

      lrst_pkg::S_APRD: begin
        sum_re  = 1'b1;
        pend_re = 1'b1;
        raddr   = ap_node_q;
        state_d = lrst_pkg::S_APM0;
      end

      lrst_pkg::S_APM0: begin
        mac_ctl = '{en: 1'b1, upper: 1'b0};
        state_d = lrst_pkg::S_APM1;
      end

      lrst_pkg::S_APM1: begin
        mac_ctl = '{en: 1'b1, upper: 1'b1};
        state_d = lrst_pkg::S_APWR;
      end

      lrst_pkg::S_APWR: begin
        sum_we     = 1'b1;
        pend_we    = 1'b1;
        waddr      = ap_node_q;
        sum_wdata  = sum_rdata + mac_prod;
        pend_wdata = pend_rdata + ap_val_q;
        unique case (ap_ret_q)
          lrst_pkg::RET_PD_RIGHT: begin
            ap_node_d = t_right;
            ap_cnt_d  = PW'(t_hi - t_mid);
            ap_ret_d  = lrst_pkg::RET_PD_CLEAR;
            state_d   = lrst_pkg::S_APRD;
          end
          lrst_pkg::RET_PD_CLEAR: state_d = lrst_pkg::S_PDCLR;
          default:                state_d = lrst_pkg::S_POP;
        endcase
      end

      lrst_pkg::S_PDCLR: begin
        pend_we        = 1'b1;
        pend_wdata     = '0;
        stk_ph_d[sp_q] = lrst_pkg::PH_LEFT;
        state_d        = lrst_pkg::S_VISIT;
      end

      lrst_pkg::S_FIXL: begin
        left_d  = sum_rdata;
        sum_re  = 1'b1;
        raddr   = t_right;
        state_d = lrst_pkg::S_FIXR;
      end

      lrst_pkg::S_FIXR: begin
        sum_we    = 1'b1;
        sum_wdata = left_q + sum_rdata;
        state_d   = lrst_pkg::S_POP;
      end

      lrst_pkg::S_POP: begin
        if (sp_q == '0) begin
          if (mode_q == lrst_pkg::MODE_QUERY) begin
            res_valid_d = 1'b1;
            res_sum_d   = acc_q;
            res_err_d   = 1'b0;
          end
          state_d = lrst_pkg::S_IDLE;
        end else begin
          sp_d    = SPW'(sp_q - 1'b1);
          state_d = lrst_pkg::S_VISIT;
        end
      end

      default: state_d = lrst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrst_pkg::S_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      size_q      <= PW'(POSITIONS);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      size_q      <= size_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stk_node_q <= stk_node_d;
    stk_lo_q   <= stk_lo_d;
    stk_hi_q   <= stk_hi_d;
    stk_ph_q   <= stk_ph_d;
    mode_q     <= mode_d;
    a_q        <= a_d;
    b_q        <= b_d;
    v_q        <= v_d;
    acc_q      <= acc_d;
    left_q     <= left_d;
    ap_node_q  <= ap_node_d;
    ap_cnt_q   <= ap_cnt_d;
    ap_val_q   <= ap_val_d;
    ap_ret_q   <= ap_ret_d;
    res_sum_q  <= res_sum_d;
    res_err_q  <= res_err_d;
  end

  assign busy                  = (state_q != lrst_pkg::S_IDLE);
  // size changes only between items: during the sweep or idle with no start
  assign cfg_ready_o           = (state_q == lrst_pkg::S_CLEAR)
                              || ((state_q == lrst_pkg::S_IDLE) && !start);
  assign result_valid_o        = res_valid_q;
  assign result_o.interval_sum = res_sum_q;
  assign result_o.range_error  = res_err_q;

endmodule
